// ===== rtl/hlpn_pkg.sv =====
// ----------------------------------------------------------------------------
// hlpn_pkg
// shared types, constants and offset tables for the hex lattice neighbor block
// ----------------------------------------------------------------------------
`default_nettype none

package hlpn_pkg;

  localparam int CFG_W   = 10;  // width of the extent registers
  localparam int SITE_W  = 18;  // site and neighbor index width
  localparam int SLOT_W  = 4;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;
  localparam int N_SHELL1 = 6;
  localparam int N_SHELL2 = 12;

  // divider: quotient bits retired per cycle
  localparam int DIV_BITS = 3;
  localparam int DIV_CYC  = SITE_W / DIV_BITS;
  localparam int CNT_W    = $clog2(DIV_CYC + 1);

  typedef enum logic [1:0] {
    REG_ROWS  = 2'd0,
    REG_COLS  = 2'd1,
    REG_SHELL = 2'd2
  } reg_idx_t;

  // clamped configuration seen by the datapath
  typedef struct packed {
    logic [CFG_W-1:0] rows;
    logic [CFG_W-1:0] cols;
    logic             shell;
  } cfg_t;

  // classified site, queued between front and back
  typedef struct packed {
    logic             err;
    logic [CFG_W-1:0] row;
    logic [CFG_W-1:0] col;
  } entry_t;

  function automatic logic signed [2:0] off_row(input logic shell, input logic [SLOT_W-1:0] k);
    logic signed [2:0] d;
    d = 3'sd0;
    if (!shell) begin
      case (k)
        4'd1, 4'd2: d = -3'sd1;
        4'd4, 4'd5: d = 3'sd1;
        default:    d = 3'sd0;
      endcase
    end else begin
      case (k)
        4'd1, 4'd5:       d = -3'sd1;
        4'd2, 4'd3, 4'd4: d = -3'sd2;
        4'd7, 4'd11:      d = 3'sd1;
        4'd8, 4'd9, 4'd10: d = 3'sd2;
        default:          d = 3'sd0;
      endcase
    end
    return d;
  endfunction

  function automatic logic signed [2:0] off_col(input logic shell, input logic [SLOT_W-1:0] k);
    logic signed [2:0] d;
    d = 3'sd0;
    if (!shell) begin
      case (k)
        4'd0, 4'd5: d = -3'sd1;
        4'd2, 4'd3: d = 3'sd1;
        default:    d = 3'sd0;
      endcase
    end else begin
      case (k)
        4'd0, 4'd10, 4'd11: d = -3'sd2;
        4'd1, 4'd9:         d = -3'sd1;
        4'd3, 4'd7:         d = 3'sd1;
        4'd4, 4'd5, 4'd6:   d = 3'sd2;
        default:            d = 3'sd0;
      endcase
    end
    return d;
  endfunction

  // (pos + d) mod ext for pos < ext, d in -2..2, ext >= 1
  function automatic logic [CFG_W-1:0] wrap(input logic [CFG_W-1:0] pos,
                                            input logic signed [2:0] d,
                                            input logic [CFG_W-1:0] ext);
    logic signed [CFG_W+1:0] s;
    logic signed [CFG_W+1:0] e;
    logic [CFG_W-1:0] r;
    s = $signed({2'b00, pos}) + (CFG_W+2)'(d);
    e = $signed({2'b00, ext});
    if (ext == CFG_W'(1)) begin
      r = '0;
    end else if (s < 0) begin
      r = CFG_W'(s + e);
    end else if (s >= e) begin
      r = CFG_W'(s - e);
    end else begin
      r = CFG_W'(s);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/hlpn_front.sv =====
// ----------------------------------------------------------------------------
// hlpn_front
// accepts a site, splits it into row and column, classifies it as valid or error
// ----------------------------------------------------------------------------
`default_nettype none

module hlpn_front
  import hlpn_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [SITE_W-1:0] site,
  input  wire cfg_t              cfg,
  output logic                   push_valid,
  input  wire logic              push_ready,
  output entry_t                 push_entry
);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [CFG_W-1:0]  rem;
  logic [SITE_W-1:0] dq;      // dividend shifts out, quotient shifts in
  logic [CFG_W-1:0]  rem_next;
  logic [SITE_W-1:0] dq_next;
  logic [CFG_W:0]    trial;
  logic              done;

  // three restoring steps per cycle
  always_comb begin
    rem_next = rem;
    dq_next  = dq;
    trial    = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial   = {rem_next, dq_next[SITE_W-1]};
      dq_next = {dq_next[SITE_W-2:0], 1'b0};
      if (trial >= {1'b0, cfg.cols}) begin
        trial      = trial - {1'b0, cfg.cols};
        dq_next[0] = 1'b1;
      end
      rem_next = trial[CFG_W-1:0];
    end
  end

  assign done       = busy && (cnt == CNT_W'(DIV_CYC));
  assign in_ready   = !busy;
  assign push_valid = done;

  // quotient at or past rows means site is at or past rows * cols
  assign push_entry.err = (cfg.rows == '0) || (cfg.cols == '0) ||
                          (dq >= SITE_W'(cfg.rows));
  assign push_entry.row = dq[CFG_W-1:0];
  assign push_entry.col = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (in_valid && in_ready) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (done) begin
      if (push_ready) begin
        busy <= 1'b0;
      end
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      dq  <= site;
      rem <= '0;
    end else if (busy && !done) begin
      dq  <= dq_next;
      rem <= rem_next;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cnt <= CNT_W'(DIV_CYC)))
    else $error("divider step count overran");

endmodule

`default_nettype wire

// ===== rtl/hlpn_queue.sv =====
// ----------------------------------------------------------------------------
// hlpn_queue
// two-entry queue of classified sites between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module hlpn_queue
  import hlpn_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_entry,
  output logic        not_full,
  input  wire logic   pop,
  output logic        not_empty,
  output entry_t      head
);

  entry_t     store [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign not_full  = (count != 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = store[rd_ptr];
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("queue count out of range");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ===== rtl/hlpn_back.sv =====
// ----------------------------------------------------------------------------
// hlpn_back
// walks each queued site's neighbor slots, one result per cycle unless stalled
// ----------------------------------------------------------------------------
`default_nettype none

module hlpn_back
  import hlpn_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire cfg_t   cfg,
  input  wire logic   q_valid,
  input  wire entry_t q_head,
  output logic        q_pop,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [SITE_W-1:0] neighbor,
  output logic [SLOT_W-1:0] slot,
  output logic              last,
  output logic              site_error
);

  localparam int SUM_W = 2 * CFG_W + 1;

  logic [SLOT_W-1:0] k;
  logic              en;
  logic              k_last;
  logic              issue;

  // stage a: wrapped coordinates
  logic              a_valid;
  logic [CFG_W-1:0]  a_nx;
  logic [CFG_W-1:0]  a_ny;
  logic [SLOT_W-1:0] a_slot;
  logic              a_last;
  logic              a_err;

  logic [SUM_W-1:0]  lin;

  assign en     = !out_valid || out_ready;
  assign k_last = q_head.err ||
                  (cfg.shell ? (k == SLOT_W'(N_SHELL2 - 1)) : (k == SLOT_W'(N_SHELL1 - 1)));
  assign issue  = en && q_valid;
  assign q_pop  = issue && k_last;

  assign lin = SUM_W'(a_nx) * SUM_W'(cfg.cols) + SUM_W'(a_ny);

  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= '0;
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_valid   <= q_valid;
      out_valid <= a_valid;
      if (issue) begin
        k <= k_last ? '0 : k + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (q_head.err) begin
        a_nx <= '0;
        a_ny <= '0;
      end else begin
        a_nx <= wrap(q_head.row, off_row(cfg.shell, k), cfg.rows);
        a_ny <= wrap(q_head.col, off_col(cfg.shell, k), cfg.cols);
      end
      a_slot <= k;
      a_last <= k_last;
      a_err  <= q_head.err;

      neighbor   <= a_err ? '0 : SITE_W'(lin);
      slot       <= a_slot;
      last       <= a_last;
      site_error <= a_err;
    end
  end

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && site_error) |-> (last && slot == '0))
    else $error("error result not a single slot zero transaction");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (slot <= SLOT_W'(N_SHELL2 - 1)))
    else $error("slot out of range");

endmodule

`default_nettype wire

// ===== rtl/hex_lattice_periodic_neighbors.sv =====
// ----------------------------------------------------------------------------
// hex_lattice_periodic_neighbors
// neighbor index generator for a periodic hexagonal lattice
// ----------------------------------------------------------------------------
// Each input transaction carries a linear site index (row * cols + column).
// The block splits it by an iterative divider (three quotient bits a cycle)
// and then emits 6 first-shell or 12 second-shell neighbor indices, selected
// by the shell register, one output transaction per cycle while m_tready is
// high, each with its slot number and tlast on the final one. Coordinates
// wrap modulo rows and cols; rows and cols above MAX_SIDE are saturated to it.
// A site at or past rows * cols, or any site while rows or cols is zero,
// gives a single transaction with neighbor 0, slot 0, tlast and tuser set.
// The front takes no new site until the divider has finished the last one
// and pushed it into the two-entry queue; the back emits one result a cycle
// while m_tready is high. A site's first result passes the divider, the
// queue, stage a and the output register before it is presented.
// Registers (APB, byte address): 0x0 rows, 0x4 cols, 0x8 shell; change them
// only while no transaction is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module hex_lattice_periodic_neighbors
  import hlpn_pkg::*;
#(
  parameter int MAX_SIDE = 512
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // apb configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  // site stream in
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [23:0]       s_tdata,   // [17:0] site, [23:18] zero
  // neighbor stream out
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic      [23:0]       m_tdata,   // [17:0] neighbor, [21:18] slot, [23:22] zero
  output logic                   m_tlast,
  output logic                   m_tuser    // [0] site_error
);

  // raw registers
  logic [CFG_W-1:0] rows;
  logic [CFG_W-1:0] cols;
  logic             shell;

  cfg_t   cfg;
  logic   wr_en;
  logic   push_valid;
  logic   push_ready;
  entry_t push_entry;
  logic   q_valid;
  logic   q_pop;
  entry_t q_head;

  logic [SITE_W-1:0] neighbor;
  logic [SLOT_W-1:0] slot;
  logic              last;
  logic              site_error;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows  <= CFG_W'(N_SHELL1);
      cols  <= CFG_W'(N_SHELL1);
      shell <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_ROWS:  rows  <= pwdata[CFG_W-1:0];
        REG_COLS:  cols  <= pwdata[CFG_W-1:0];
        REG_SHELL: shell <= pwdata[0];
        default: ;  // unused address, write dropped
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_ROWS:  prdata = DATA_W'(rows);
      REG_COLS:  prdata = DATA_W'(cols);
      REG_SHELL: prdata = DATA_W'(shell);
      default:   prdata = '0;
    endcase
  end

  // saturate extents to the largest supported side
  assign cfg.rows  = (32'(rows) > MAX_SIDE) ? CFG_W'(MAX_SIDE) : rows;
  assign cfg.cols  = (32'(cols) > MAX_SIDE) ? CFG_W'(MAX_SIDE) : cols;
  assign cfg.shell = shell;

  // front: divide and classify
  hlpn_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .site       (s_tdata[SITE_W-1:0]),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  // decoupling queue
  hlpn_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push_valid),
    .push_entry (push_entry),
    .not_full   (push_ready),
    .pop        (q_pop),
    .not_empty  (q_valid),
    .head       (q_head)
  );

  // back: slot sequencer and index arithmetic
  hlpn_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .neighbor   (neighbor),
    .slot       (slot),
    .last       (last),
    .site_error (site_error)
  );

  assign m_tdata = {2'b00, slot, neighbor};
  assign m_tlast = last;
  assign m_tuser = site_error;

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("error transaction without tlast");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the periodic hex lattice neighbor generator
// ----------------------------------------------------------------------------
// Sends site indices on the input stream and checks every neighbor transaction
// against an in-bench predictor. The predictor keeps its own copy of rows,
// cols and shell, splits each site into row and column, and walks the first or
// second shell offsets with periodic wrap. Directed cases cover the reset
// lattice, both shells, the largest and saturated extents, tiny and odd
// extents, zero extents, out-of-range sites and an unmapped register address.
// A random sweep then runs under three idling mixes, and one stretch holds the
// output off long enough for the block to stall its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
  import hlpn_pkg::*;
();

  localparam int SIDE_CAP       = 512;    // extents saturate here
  localparam int WATCHDOG_LIMIT = 3000;   // cycles with no transaction at all
  localparam int LONG_STALL     = 400;    // output hold-off for the pressure test
  localparam int DRAIN_PAUSE    = 16;     // extra cycles once nothing is pending

  // register byte addresses, plus one that maps to nothing
  localparam logic [ADDR_W-1:0] ADDR_ROWS  = {REG_ROWS, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_COLS  = {REG_COLS, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_SHELL = {REG_SHELL, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_SPARE = 4'hC;

  // one neighbor transaction as the bench sees it
  typedef struct packed {
    logic              site_error;
    logic              last;
    logic [SLOT_W-1:0] slot;
    logic [SITE_W-1:0] neighbor;
  } nbr_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              s_tvalid;
  logic              s_tready;
  logic [23:0]       s_tdata;   // [17:0] site, [23:18] zero
  logic              m_tvalid;
  logic              m_tready;
  logic [23:0]       m_tdata;   // [17:0] neighbor, [21:18] slot, [23:22] zero
  logic              m_tlast;
  logic              m_tuser;   // [0] site_error

  // shadow of the lattice registers, as written
  logic [CFG_W-1:0] lat_rows;
  logic [CFG_W-1:0] lat_cols;
  logic             lat_shell;

  // neighbors predicted but not yet seen on the output
  nbr_t pending_neighbors[$];
  nbr_t seen_nbr;
  nbr_t want_nbr;

  // idling knobs, percent of cycles
  int send_idle_pct;
  int recv_idle_pct;
  int stall_left;

  // bookkeeping
  int mismatches;
  int sites_sent;
  int results_seen;
  int error_results;
  int settings_used;
  int quiet_cycles;

  hex_lattice_periodic_neighbors dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // 20 time unit clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // register value as the datapath uses it
  function automatic int side_of(input logic [CFG_W-1:0] v);
    return (int'(v) > SIDE_CAP) ? SIDE_CAP : int'(v);
  endfunction

  // periodic wrap, pos < ext, step in -2..2
  function automatic int wrap_coord(input int pos, input int step, input int ext);
    return (pos + 2 * ext + step) % ext;
  endfunction

  // (row, column) step of slot k, first shell then second shell ring order
  task automatic shell_offset(input logic second, input int k,
                              output int dr, output int dc);
    dr = 0;
    dc = 0;
    if (!second) begin
      case (k)
        0: begin dr =  0; dc = -1; end
        1: begin dr = -1; dc =  0; end
        2: begin dr = -1; dc =  1; end
        3: begin dr =  0; dc =  1; end
        4: begin dr =  1; dc =  0; end
        default: begin dr = 1; dc = -1; end
      endcase
    end else begin
      case (k)
        0:  begin dr =  0; dc = -2; end
        1:  begin dr = -1; dc = -1; end
        2:  begin dr = -2; dc =  0; end
        3:  begin dr = -2; dc =  1; end
        4:  begin dr = -2; dc =  2; end
        5:  begin dr = -1; dc =  2; end
        6:  begin dr =  0; dc =  2; end
        7:  begin dr =  1; dc =  1; end
        8:  begin dr =  2; dc =  0; end
        9:  begin dr =  2; dc = -1; end
        10: begin dr =  2; dc = -2; end
        default: begin dr = 1; dc = -2; end
      endcase
    end
  endtask

  // queue up the neighbors one site should produce under the current lattice
  task automatic predict_neighbors(input logic [SITE_W-1:0] site);
    int   a;
    int   b;
    int   r;
    int   c;
    int   n;
    int   dr;
    int   dc;
    nbr_t e;
    a = side_of(lat_rows);
    b = side_of(lat_cols);
    if (a == 0 || b == 0 || int'(site) >= a * b) begin
      // no such site: single flagged transaction
      e.neighbor   = '0;
      e.slot       = '0;
      e.last       = 1'b1;
      e.site_error = 1'b1;
      pending_neighbors.push_back(e);
    end else begin
      r = int'(site) / b;
      c = int'(site) % b;
      n = lat_shell ? N_SHELL2 : N_SHELL1;
      for (int k = 0; k < n; k++) begin
        shell_offset(lat_shell, k, dr, dc);
        e.neighbor   = SITE_W'(wrap_coord(r, dr, a) * b + wrap_coord(c, dc, b));
        e.slot       = SLOT_W'(k);
        e.last       = (k == n - 1);
        e.site_error = 1'b0;
        pending_neighbors.push_back(e);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // output side: ready generator and result checker
  // ---------------------------------------------------------------------------

  // ready drops at random, or for a counted stretch when a test asks for it
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready = 1'b0;
      stall_left--;
    end else begin
      m_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // every output transaction must match the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_nbr.neighbor   = m_tdata[SITE_W-1:0];
      seen_nbr.slot       = m_tdata[SITE_W +: SLOT_W];
      seen_nbr.last       = m_tlast;
      seen_nbr.site_error = m_tuser;
      results_seen++;
      if (m_tuser) error_results++;
      if (pending_neighbors.size() == 0) begin
        $display("%0t: unexpected transaction: got neighbor %0d slot %0d last %0b err %0b",
                 $time, seen_nbr.neighbor, seen_nbr.slot, seen_nbr.last,
                 seen_nbr.site_error);
        mismatches++;
      end else begin
        want_nbr = pending_neighbors.pop_front();
        if (seen_nbr.neighbor !== want_nbr.neighbor || seen_nbr.slot !== want_nbr.slot ||
            seen_nbr.last !== want_nbr.last ||
            seen_nbr.site_error !== want_nbr.site_error) begin
          $display("%0t: mismatch: expected neighbor %0d slot %0d last %0b err %0b",
                   $time, want_nbr.neighbor, want_nbr.slot, want_nbr.last,
                   want_nbr.site_error);
          $display("%0t:           actual   neighbor %0d slot %0d last %0b err %0b",
                   $time, seen_nbr.neighbor, seen_nbr.slot, seen_nbr.last,
                   seen_nbr.site_error);
          mismatches++;
        end
      end
    end
  end

  // watchdog: any transaction or register access counts as progress
  always @(posedge clk) begin
    if (rst || psel || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d neighbors still pending",
               $time, quiet_cycles, pending_neighbors.size());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // drivers, all entered and left just after a falling edge
  // ---------------------------------------------------------------------------

  // apb write: setup cycle, then access cycle until pready
  task automatic cfg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    // mirror what the block keeps of the write
    case (addr)
      ADDR_ROWS:  lat_rows  = value[CFG_W-1:0];
      ADDR_COLS:  lat_cols  = value[CFG_W-1:0];
      ADDR_SHELL: lat_shell = value[0];
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // offer one site, with random idle cycles first, and predict on acceptance
  task automatic send_site(input logic [SITE_W-1:0] site);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {6'b0, site};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_neighbors(site);
    sites_sent++;
    @(negedge clk);
  endtask

  // let every pending neighbor come out, then give the block time to settle
  task automatic drain_block();
    s_tvalid = 1'b0;
    while (pending_neighbors.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
    @(negedge clk);
  endtask

  // reprogram the lattice once idle; upper data bits are junk on purpose
  task automatic apply_lattice(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols,
                               input logic shell);
    drain_block();
    cfg_write(ADDR_ROWS,  {22'($urandom), rows});
    cfg_write(ADDR_COLS,  {22'($urandom), cols});
    cfg_write(ADDR_SHELL, {31'($urandom), shell});
    settings_used++;
  endtask

  // random extent: mostly small, some mid, some saturated, a few degenerate
  function automatic logic [CFG_W-1:0] pick_extent();
    int r;
    r = $urandom_range(99);
    if (r < 50) return CFG_W'($urandom_range(3, 24));
    if (r < 70) return CFG_W'($urandom_range(25, SIDE_CAP));
    if (r < 80) return CFG_W'($urandom_range(SIDE_CAP + 1, 1023));
    if (r < 88) return CFG_W'(SIDE_CAP);
    if (r < 97) return CFG_W'($urandom_range(1, 2));
    return '0;
  endfunction

  // random site: mostly valid, some just past the end, some anywhere
  function automatic logic [SITE_W-1:0] pick_site();
    int total;
    int r;
    total = side_of(lat_rows) * side_of(lat_cols);
    r = $urandom_range(99);
    if (total > 0 && r < 82) return SITE_W'($urandom_range(total - 1));
    if (total < (1 << SITE_W) && r < 90) begin
      if (total + 3 >= (1 << SITE_W)) return SITE_W'(total);
      return SITE_W'(total + $urandom_range(3));
    end
    return SITE_W'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset lattice is 6 by 6, first shell: corners, wrap on every side, overrun
  task automatic test_reset_lattice();
    send_site(18'd0);
    send_site(18'd5);
    send_site(18'd30);
    send_site(18'd35);
    send_site(18'd36);
    send_site(18'h3FFFF);
  endtask

  // second shell on the reset extents, plus a write to an unmapped address
  task automatic test_second_shell();
    apply_lattice(10'd6, 10'd6, 1'b1);
    cfg_write(ADDR_SPARE, 32'hFFFF_FFFF);
    send_site(18'd0);
    send_site(18'd14);
    send_site(18'd35);
  endtask

  // full 512 by 512 lattice, then register values that saturate to it
  task automatic test_largest_lattice();
    apply_lattice(10'd512, 10'd512, 1'b1);
    send_site(18'd0);
    send_site(18'h3FFFF);
    send_site(18'd261632);
    apply_lattice(10'd1023, 10'd1023, 1'b0);
    send_site(18'h3FFFF);
    send_site(18'h15555);
  endtask

  // extents of one and two fold offsets back onto the same sites; odd rows
  task automatic test_tiny_and_odd();
    apply_lattice(10'd1, 10'd1, 1'b1);
    send_site(18'd0);
    send_site(18'd1);
    apply_lattice(10'd2, 10'd2, 1'b1);
    send_site(18'd3);
    send_site(18'd2);
    apply_lattice(10'd3, 10'd7, 1'b0);
    send_site(18'd20);
  endtask

  // a zero extent leaves no sites, so every site is flagged
  task automatic test_zero_extent();
    apply_lattice(10'd0, 10'd6, 1'b0);
    send_site(18'd0);
    apply_lattice(10'd6, 10'd0, 1'b1);
    send_site(18'd0);
  endtask

  // random lattices and sites under one idling mix
  task automatic test_random_sweep(input int send_pct, input int recv_pct, input int n_sites);
    int done;
    int block;
    done = 0;
    while (done < n_sites) begin
      apply_lattice(pick_extent(), pick_extent(), 1'($urandom));
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      block = $urandom_range(20, 40);
      for (int i = 0; i < block && done < n_sites; i++) begin
        send_site(pick_site());
        done++;
      end
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  // output held off for a long stretch while the sender keeps offering sites
  task automatic test_output_stall();
    apply_lattice(CFG_W'($urandom_range(6, 40)), CFG_W'($urandom_range(6, 40)), 1'b1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_left    = LONG_STALL;
    for (int i = 0; i < 24; i++) send_site(pick_site());
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    m_tready      = 1'b0;
    lat_rows      = 10'd6;
    lat_cols      = 10'd6;
    lat_shell     = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_left    = 0;
    mismatches    = 0;
    sites_sent    = 0;
    results_seen  = 0;
    error_results = 0;
    settings_used = 1;
    quiet_cycles  = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_lattice();
    test_second_shell();
    test_largest_lattice();
    test_tiny_and_odd();
    test_zero_extent();
    test_random_sweep(33, 47, 135);
    test_random_sweep(47, 33, 135);
    test_output_stall();
    test_random_sweep(0, 0, 135);

    // everything in flight has to land, then a few quiet cycles for strays
    drain_block();
    repeat (20) @(posedge clk);

    $display("covered %0d sites over %0d lattice settings, both shells, idling and a long stall",
             sites_sent, settings_used);
    $display("checked %0d neighbor transactions, %0d of them flagged out of range, %0d mismatches",
             results_seen, error_results, mismatches);
    if (mismatches == 0 && pending_neighbors.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/hlpn_pkg.sv
rtl/hlpn_front.sv
rtl/hlpn_queue.sv
rtl/hlpn_back.sv
rtl/hex_lattice_periodic_neighbors.sv
tb/sv/tb_top.sv
